// ===== design/dtp_pkg.sv =====
// Shared types, character codes and calendar helpers for the dotted date parser.
package dtp_pkg;

    localparam int YEAR_W  = 16;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int MOD_W   = 9;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] PART_DAY   = 2'd0;
    localparam logic [1:0] PART_MONTH = 2'd1;
    localparam logic [1:0] PART_YEAR  = 2'd2;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam int LEAP_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int RADIX      = 10;

    typedef struct packed {
        logic                 valid_res;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
    } dtp_result_t;

    // Advance a running remainder modulo 400 by one decimal digit.
    function automatic logic [MOD_W-1:0] mod400_step(input logic [MOD_W-1:0] r,
                                                     input logic [3:0] d);
        logic [11:0] v;
        logic [11:0] sub;
        v   = 12'(r) * 12'(RADIX) + 12'(d);
        sub = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (v >= 12'(k * LEAP_CYCLE))
            begin
                sub = 12'(k * LEAP_CYCLE);
            end
        end
        return MOD_W'(v - sub);
    endfunction

    // Leap year from the year's remainder modulo 400.
    function automatic logic is_leap(input logic [MOD_W-1:0] r400);
        logic leap;
        if (r400 == '0)
        begin
            leap = 1'b1;
        end
        else if (r400 == MOD_W'(CENTURY) || r400 == MOD_W'(2 * CENTURY) ||
                 r400 == MOD_W'(3 * CENTURY))
        begin
            leap = 1'b0;
        end
        else
        begin
            leap = (r400[1:0] == 2'b00);
        end
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB:                            len = leap ? 5'd29 : 5'd28;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/dotted_date_parser_validator_top.sv =====
// Top level of the dotted date parser: input stage, parser, result register.
//
// Takes one character per cycle while in_stall is low. A NUL ends a string and
// produces one result (valid_res, day, month, year) in the result register;
// other characters produce nothing. Each character passes through an input
// register and the parse logic (a multiply-by-ten add on the number being built,
// plus constant compares), and a NUL's result into the result register. The
// input stalls only when a NUL sits in the input register while the result
// register is full and stalled downstream. NUMBER_WIDTH (12 to 32) caps every
// number at the smaller of 2^NUMBER_WIDTH - 1 and 65535; a larger number gives
// an invalid result.
module dotted_date_parser_validator_top #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [15:0] year
);
    import dtp_pkg::*;

    localparam int ACC_W = (NUMBER_WIDTH < YEAR_W) ? NUMBER_WIDTH : YEAR_W;

    logic        s1_valid;
    logic [7:0]  s1_ch;
    logic        s1_nul;
    logic        advance;
    logic        fire;
    logic        out_free;
    dtp_result_t res_next;
    dtp_result_t res_q;

    // A non-terminator always moves on; a terminator needs room for its result.
    assign advance = !s1_nul || out_free;
    assign fire    = s1_valid && advance;

    dtp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ch       (ch),
        .advance  (advance),
        .in_stall (in_stall),
        .s1_valid (s1_valid),
        .s1_ch    (s1_ch)
    );

    dtp_parser #(
        .ACC_W (ACC_W)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .ch     (s1_ch),
        .is_nul (s1_nul),
        .res    (res_next)
    );

    dtp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_req  (s1_valid && s1_nul),
        .res_in    (res_next),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign valid_res = res_q.valid_res;
    assign day       = res_q.day;
    assign month     = res_q.month;
    assign year      = res_q.year;

endmodule

// ===== design/dtp_in_reg.sv =====
// Input register stage holding one character transaction.
module dtp_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] ch,
    input  logic       advance,
    output logic       in_stall,
    output logic       s1_valid,
    output logic [7:0] s1_ch
);
    import dtp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;

    // Hold while the staged character cannot move on.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            ch_reg <= ch;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_ch    = ch_reg;

endmodule

// ===== design/dtp_parser.sv =====
// Parse state and per-character update, plus the date check done at string end.
module dtp_parser #(
    parameter int ACC_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           ch,
    output logic                 is_nul,
    output dtp_pkg::dtp_result_t res
);
    import dtp_pkg::*;

    logic [ACC_W-1:0] acc_reg,   acc_next;
    logic [MOD_W-1:0] r400_reg,  r400_next;
    logic             ovf_reg,   ovf_next;
    logic [1:0]       part_reg,  part_next;
    logic             err_reg,   err_next;
    logic [ACC_W-1:0] day_reg,   day_next;
    logic [ACC_W-1:0] month_reg, month_next;

    logic [ACC_W+3:0] prod;
    logic             is_digit;
    logic             month_ok;
    logic             ok;
    logic [MONTH_W-1:0] m4;
    logic [DAY_W-1:0]   mlen;

    assign is_nul   = (ch == CH_NUL);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign prod     = (ACC_W + 4)'(acc_reg) * (ACC_W + 4)'(RADIX) + (ACC_W + 4)'(ch[3:0]);

    always_comb
    begin
        acc_next   = acc_reg;
        r400_next  = r400_reg;
        ovf_next   = ovf_reg;
        part_next  = part_reg;
        err_next   = err_reg;
        day_next   = day_reg;
        month_next = month_reg;
        if (fire)
        begin
            if (is_nul)
            begin
                acc_next   = '0;
                r400_next  = '0;
                ovf_next   = 1'b0;
                part_next  = PART_DAY;
                err_next   = 1'b0;
                day_next   = '0;
                month_next = '0;
            end
            else if (!err_reg)
            begin
                if (is_digit)
                begin
                    r400_next = mod400_step(r400_reg, ch[3:0]);
                    // Saturate at the limit and flag it.
                    if (prod[ACC_W+3:ACC_W] != '0)
                    begin
                        ovf_next = 1'b1;
                        acc_next = '1;
                    end
                    else
                    begin
                        acc_next = prod[ACC_W-1:0];
                    end
                end
                else if (ch == CH_DOT)
                begin
                    case (part_reg)
                        PART_DAY:   day_next   = acc_reg;
                        PART_MONTH: month_next = acc_reg;
                        default:    err_next   = 1'b1;
                    endcase
                    if (part_reg != PART_YEAR)
                    begin
                        part_next = part_reg + 2'd1;
                        acc_next  = '0;
                        r400_next = '0;
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            r400_reg  <= '0;
            ovf_reg   <= 1'b0;
            part_reg  <= PART_DAY;
            err_reg   <= 1'b0;
            day_reg   <= '0;
            month_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            r400_reg  <= r400_next;
            ovf_reg   <= ovf_next;
            part_reg  <= part_next;
            err_reg   <= err_next;
            day_reg   <= day_next;
            month_reg <= month_next;
        end
    end

    // Date check against the state left before the terminator.
    assign month_ok = (month_reg >= ACC_W'(MON_JAN)) && (month_reg <= ACC_W'(MON_DEC));
    assign m4       = MONTH_W'(month_reg);
    assign mlen     = month_length(m4, is_leap(r400_reg));

    assign ok = !err_reg && !ovf_reg && (part_reg == PART_YEAR) && (acc_reg != '0) &&
                month_ok && (day_reg != '0) && (day_reg <= ACC_W'(mlen));

    always_comb
    begin
        res.valid_res = ok;
        res.day       = ok ? DAY_W'(day_reg) : '0;
        res.month     = ok ? m4 : '0;
        res.year      = ok ? YEAR_W'(acc_reg) : '0;
    end

`ifndef SYNTHESIS
    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        part_reg != 2'd3)
        else $error("dot count out of range");

    a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_nul |=> part_reg == PART_DAY && !err_reg && !ovf_reg && acc_reg == '0)
        else $error("state not cleared after string end");

    a_err_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg && !(fire && is_nul) |=> $stable(acc_reg) && $stable(part_reg))
        else $error("state changed after error");
`endif

endmodule

// ===== design/dtp_out_reg.sv =====
// Result register that holds one date transaction until it is taken.
module dtp_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_req,
    input  dtp_pkg::dtp_result_t res_in,
    input  logic                 out_stall,
    output logic                 free,
    output logic                 out_valid,
    output dtp_pkg::dtp_result_t res_out
);
    import dtp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dtp_result_t res_reg;

    assign free       = !valid_reg || !out_stall;
    assign valid_next = free ? load_req : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load_req)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_reg.valid_res |->
            res_reg.day == '0 && res_reg.month == '0 && res_reg.year == '0)
        else $error("rejected date carries nonzero fields");

    a_valid_month: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.valid_res |->
            res_reg.month >= MON_JAN && res_reg.month <= MON_DEC && res_reg.day != '0)
        else $error("accepted date out of range");
`endif

endmodule
